// ===== rtl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Holds the transfer payloads, the command and status codes, the sequencer
// states and the sizes that follow from the list capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 8;
    localparam int ST_W      = 2;
    localparam int OUT_CNT_W = 5;
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DMP_RD,
        S_DMP_LD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] element;
        logic [OUT_CNT_W-1:0]     count;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic [DATA_W-1:0]        wdata;
        logic [IDX_W-1:0]         raddr;
    } t_ram_req;

    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_out_load;

endpackage

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed 32-bit values
// Insert and delete at the head, the tail or a 1-based position, and dump the
// whole list in order, with status and count reported for every command.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall    | command, value, position
//   out     | output    | o_out_valid / i_out_stall  | status, element, count, last
//
// One command at a time. An insert before index k moves the entries from k to the
// tail up one slot, a delete at index k moves the entries after k down one slot,
// each entry read and then written through the single read and single write port
// of the element memory. A dump streams the elements in order; an error goes
// straight to the response. Reset clears the count, the sequencer and the output
// valid flag; memory is never read past the count, so it needs no clearing pass.
// A result waits in the output register while the out channel stalls; the
// sequencer holds until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pls_pkg::t_in_item  i_in,
    output      logic               o_in_stall,
    output      logic               o_out_valid,
    output      pls_pkg::t_out_item o_out,
    input  wire logic               i_out_stall
);

    import pls_pkg::*;

    t_ram_req           w_ram;
    logic [DATA_W-1:0]  w_rdata;
    t_out_load          w_load;
    logic               w_slot_free;
    logic               w_busy;

    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    // the output register is free when empty or when its transfer completes now
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // hold off new commands while a command is being worked
    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_busy      (w_busy),
        .i_slot_free (w_slot_free),
        .o_load      (w_load),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata)
    );

    pls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_load.load) begin
            // advance: a new result takes the slot
            n_out_valid = 1'b1;
            n_out       = w_load.item;
        end else if (!i_out_stall) begin
            // drop the result once its transfer completes
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/pls_ram.sv =====
// ----------------------------------------------------------------------------
// pls_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl: command sequencer of the positional list store
// Decodes a command, walks the element memory one entry per step to open or
// close a gap or to stream a dump, and keeps the element count.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire pls_pkg::t_in_item          i_in,
    output      logic                       o_busy,
    input  wire logic                       i_slot_free,
    output      pls_pkg::t_out_load         o_load,
    output      pls_pkg::t_ram_req          o_ram,
    input  wire logic [pls_pkg::DATA_W-1:0] i_rdata
);

    import pls_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_tgt, n_tgt;
    logic [DATA_W-1:0]   r_val, n_val;
    t_status             r_st, n_st;

    t_cmd                w_cmd;
    logic                w_full;
    logic                w_empty;
    logic [CMP_W-1:0]    w_pos;
    logic [CMP_W-1:0]    w_cnt;
    logic [CNT_W:0]      w_idx_nx;
    logic [CNT_W-1:0]    w_pos_m1;

    assign w_cmd    = t_cmd'(i_in.command);
    assign w_full   = (r_cnt >= CNT_W'(CAPACITY));
    assign w_empty  = (r_cnt == '0);
    assign w_pos    = CMP_W'(i_in.position);
    assign w_cnt    = CMP_W'(r_cnt);
    assign w_idx_nx = {1'b0, r_idx} + 1'b1;
    assign w_pos_m1 = CNT_W'(i_in.position - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_tgt <= n_tgt;
        r_val <= n_val;
        r_st  <= n_st;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_tgt   = r_tgt;
        n_val   = r_val;
        n_st    = r_st;

        o_busy       = (r_state != S_IDLE);
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_idx[IDX_W-1:0];
        o_ram.wdata  = i_rdata;
        o_ram.raddr  = r_idx[IDX_W-1:0];
        o_load.load         = 1'b0;
        o_load.item.status  = r_st;
        o_load.item.element = '0;
        o_load.item.count   = OUT_CNT_W'(r_cnt);
        o_load.item.last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val   = i_in.value;
                    n_st    = ST_DONE;
                    n_state = S_RESP;
                    case (w_cmd)
                        CMD_INS_FIRST, CMD_INS_LAST: begin
                            if (w_full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_idx   = r_cnt;
                                n_tgt   = (w_cmd == CMD_INS_FIRST) ? '0 : r_cnt;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_INS_POS: begin
                            if (w_pos == '0 || w_pos > w_cnt + 1'b1) begin
                                n_st = ST_BADPOS;
                            end else if (w_full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_idx   = r_cnt;
                                n_tgt   = w_pos_m1;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_DEL_FIRST, CMD_DEL_LAST: begin
                            if (w_empty) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_idx   = (w_cmd == CMD_DEL_FIRST) ? '0 : r_cnt - 1'b1;
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_DEL_POS: begin
                            if (w_empty) begin
                                n_st = ST_EMPTY;
                            end else if (w_pos == '0 || w_pos > w_cnt) begin
                                n_st = ST_BADPOS;
                            end else begin
                                n_idx   = w_pos_m1;
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_DUMP: begin
                            if (w_empty) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                            n_st = ST_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                // drop the new value in once the gap reaches the target slot
                if (r_idx == r_tgt) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = r_val;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_ram.raddr = IDX_W'(r_idx - 1'b1);
                    n_state     = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_ram.we = 1'b1;
                n_idx    = r_idx - 1'b1;
                n_state  = S_INS_RD;
            end
            S_DEL_RD: begin
                if (w_idx_nx >= {1'b0, r_cnt}) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_ram.raddr = IDX_W'(w_idx_nx);
                    n_state     = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_ram.we = 1'b1;
                n_idx    = CNT_W'(w_idx_nx);
                n_state  = S_DEL_RD;
            end
            S_DMP_RD: begin
                n_state = S_DMP_LD;
            end
            S_DMP_LD: begin
                // read address holds, so the read data stays put while stalled
                o_load.item.status  = ST_DONE;
                o_load.item.element = i_rdata;
                o_load.item.last    = (w_idx_nx == {1'b0, r_cnt});
                if (i_slot_free) begin
                    o_load.load = 1'b1;
                    n_idx       = CNT_W'(w_idx_nx);
                    n_state     = (w_idx_nx == {1'b0, r_cnt}) ? S_IDLE : S_DMP_RD;
                end
            end
            S_RESP: begin
                if (i_slot_free) begin
                    o_load.load = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
